[rtl/ray_box_slab_intersect_assert.svh]
// assertion macros for the slab intersect block
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH

`define RBSI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define RBSI_ASSERT_NRST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/rbsi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rbsi_pkg;

   localparam int unsigned DefFracBits   = 16;
   localparam int unsigned DefCoordWidth = 32;

   localparam int unsigned NORMAL_WIDTH = 3;

   typedef enum logic [NORMAL_WIDTH-1:0] {
      NORMAL_NONE  = 3'd0,
      NORMAL_POS_X = 3'd1,
      NORMAL_NEG_X = 3'd2,
      NORMAL_POS_Y = 3'd3,
      NORMAL_NEG_Y = 3'd4
   } normal_type;

endpackage
`default_nettype wire

[rtl/rbsi_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module rbsi_div
   import rbsi_pkg::*;
#(
   parameter int unsigned FRAC_BITS   = DefFracBits,
   parameter int unsigned COORD_WIDTH = DefCoordWidth
) (
   input  wire logic                          clock,
   input  wire logic [COORD_WIDTH+1:0]        num_mag,
   input  wire logic [COORD_WIDTH-1:0]        den_mag,
   input  wire logic                          neg,
   output logic signed [COORD_WIDTH-1:0]      slab_time
);
   localparam int unsigned W   = COORD_WIDTH;
   localparam int unsigned F   = FRAC_BITS;
   localparam int unsigned NUMW = W + 2;
   localparam int unsigned NW  = NUMW + F;
   localparam int unsigned XW  = NW + W;

   logic [NW-1:0] dividend;
   logic [XW-1:0] dividend_x;
   logic [XW-1:0] den_x;
   logic [NW-1:0] top_part;

   logic [W-1:0] rem_ff  [W+1];
   logic [W-1:0] low_ff  [W+1];
   logic [W-1:0] quo_ff  [W+1];
   logic [W-1:0] den_ff  [W+1];
   logic         neg_ff  [W+1];
   logic         ovf_ff  [W+1];

   logic [W-1:0] cap;
   logic [W-1:0] mag;
   logic signed [W-1:0] time_ff;
   logic signed [W-1:0] time_in;

   assign dividend   = {num_mag, {F{1'b0}}};
   assign dividend_x = XW'(dividend);
   assign den_x      = XW'(den_mag) << W;
   assign top_part   = dividend >> W;

   // setup stage
   always_ff @(posedge clock) begin
      rem_ff[0] <= top_part[W-1:0];
      low_ff[0] <= dividend[W-1:0];
      quo_ff[0] <= '0;
      den_ff[0] <= den_mag;
      neg_ff[0] <= neg;
      ovf_ff[0] <= dividend_x >= den_x;
   end

   // one quotient bit per stage
   for (genvar k = 0; k < W; k++) begin : g_step
      logic [W:0] shifted;
      logic [W:0] diff;
      logic       ge;
      assign shifted = {rem_ff[k], low_ff[k][W-1]};
      assign ge      = shifted >= {1'b0, den_ff[k]};
      assign diff    = shifted - {1'b0, den_ff[k]};
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= ge ? diff[W-1:0] : shifted[W-1:0];
         low_ff[k+1] <= low_ff[k] << 1;
         quo_ff[k+1] <= {quo_ff[k][W-2:0], ge};
         den_ff[k+1] <= den_ff[k];
         neg_ff[k+1] <= neg_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
      end
   end

   always_comb begin
      cap = neg_ff[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      mag = (ovf_ff[W] || quo_ff[W] > cap) ? cap : quo_ff[W];
      time_in = neg_ff[W] ? W'(-mag) : mag;
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
   end

   assign slab_time = time_ff;

endmodule
`default_nettype wire

[rtl/ray_box_slab_intersect.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake                      payload
// request   in         start & !busy                  req_ray_*, req_box_*
// response  out        rsp_strobe (one cycle)         rsp_hit, rsp_entry_time, rsp_contact_*,
//                                                     rsp_normal_code
// one beat in per cycle, busy stays low
// the pipeline depth is dominated by the four slab dividers, one quotient bit per stage
// reset clears the valid bits of every stage; payload registers are not reset
// the receiver cannot stall, so the pipeline never holds
module ray_box_slab_intersect
   import rbsi_pkg::*;
#(
   parameter int unsigned FRAC_BITS   = DefFracBits,
   parameter int unsigned COORD_WIDTH = DefCoordWidth
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_origin_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_origin_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_dir_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_dir_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_box_pos_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_box_pos_y,
   input  wire logic [COORD_WIDTH-2:0]        req_box_size_x,
   input  wire logic [COORD_WIDTH-2:0]        req_box_size_y,
   output logic                               rsp_strobe,
   output logic                               rsp_hit,
   output logic signed [COORD_WIDTH-1:0]      rsp_entry_time,
   output logic signed [COORD_WIDTH-1:0]      rsp_contact_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_contact_y,
   output logic [NORMAL_WIDTH-1:0]            rsp_normal_code
);
   localparam int unsigned W    = COORD_WIDTH;
   localparam int unsigned F    = FRAC_BITS;
   localparam int unsigned NUMW = W + 2;
   localparam int unsigned TW   = W + 2;
   localparam int unsigned DLAT = W + 2;
   localparam int unsigned LAT  = W + 8;

   localparam logic signed [TW-1:0] T_NEG_INF = {2'b11, {W{1'b0}}};
   localparam logic signed [TW-1:0] T_POS_INF = {2'b00, {W{1'b1}}};
   localparam logic signed [W-1:0]  S_MIN     = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [TW-1:0] S_MAX_T   = TW'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [TW-1:0] S_MIN_T   = {3'b111, {(W-1){1'b0}}};
   localparam logic [W:0]           M_CAP     = {1'b1, {W{1'b0}}};

   typedef struct packed {
      logic signed [W-1:0] ox;
      logic signed [W-1:0] oy;
      logic signed [W-1:0] dx;
      logic signed [W-1:0] dy;
      logic                okx;
      logic                oky;
      logic                dzx;
      logic                dzy;
   } side_type;

   assign busy = 1'b0;

   // stage 0: input beat
   logic                 v0_ff;
   logic signed [W-1:0]  ox0_ff, oy0_ff, dx0_ff, dy0_ff, px0_ff, py0_ff;
   logic [W-2:0]         sx0_ff, sy0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      ox0_ff <= req_ray_origin_x;
      oy0_ff <= req_ray_origin_y;
      dx0_ff <= req_ray_dir_x;
      dy0_ff <= req_ray_dir_y;
      px0_ff <= req_box_pos_x;
      py0_ff <= req_box_pos_y;
      sx0_ff <= req_box_size_x;
      sy0_ff <= req_box_size_y;
   end

   // stage 1: edge differences
   logic signed [NUMW-1:0] oxe, oye, pxe, pye, pendx, pendy;
   logic signed [NUMW-1:0] ax_in, bx_in, ay_in, by_in;
   logic                   insx_in, insy_in;

   always_comb begin
      oxe   = NUMW'(ox0_ff);
      oye   = NUMW'(oy0_ff);
      pxe   = NUMW'(px0_ff);
      pye   = NUMW'(py0_ff);
      pendx = pxe + $signed({3'b000, sx0_ff});
      pendy = pye + $signed({3'b000, sy0_ff});
      ax_in = pxe - oxe;
      bx_in = pendx - oxe;
      ay_in = pye - oye;
      by_in = pendy - oye;
      insx_in = (pxe < oxe) && (oxe < pendx);
      insy_in = (pye < oye) && (oye < pendy);
   end

   logic                   v1_ff;
   logic signed [NUMW-1:0] ax1_ff, bx1_ff, ay1_ff, by1_ff;
   side_type               side1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      ax1_ff <= ax_in;
      bx1_ff <= bx_in;
      ay1_ff <= ay_in;
      by1_ff <= by_in;
      side1_ff.ox  <= ox0_ff;
      side1_ff.oy  <= oy0_ff;
      side1_ff.dx  <= dx0_ff;
      side1_ff.dy  <= dy0_ff;
      side1_ff.dzx <= dx0_ff == '0;
      side1_ff.dzy <= dy0_ff == '0;
      side1_ff.okx <= (dx0_ff != '0) || insx_in;
      side1_ff.oky <= (dy0_ff != '0) || insy_in;
   end

   // slab dividers
   logic [W-1:0]    dxm, dym;
   logic [NUMW-1:0] axm, bxm, aym, bym;
   logic signed [W-1:0] tax, tbx, tay, tby;

   assign dxm = side1_ff.dx[W-1] ? W'(-side1_ff.dx) : side1_ff.dx;
   assign dym = side1_ff.dy[W-1] ? W'(-side1_ff.dy) : side1_ff.dy;
   assign axm = ax1_ff[NUMW-1] ? NUMW'(-ax1_ff) : ax1_ff;
   assign bxm = bx1_ff[NUMW-1] ? NUMW'(-bx1_ff) : bx1_ff;
   assign aym = ay1_ff[NUMW-1] ? NUMW'(-ay1_ff) : ay1_ff;
   assign bym = by1_ff[NUMW-1] ? NUMW'(-by1_ff) : by1_ff;

   rbsi_div #(.FRAC_BITS(F), .COORD_WIDTH(W)) u_div_ax (
      .clock(clock), .num_mag(axm), .den_mag(dxm),
      .neg(ax1_ff[NUMW-1] ^ side1_ff.dx[W-1]), .slab_time(tax));
   rbsi_div #(.FRAC_BITS(F), .COORD_WIDTH(W)) u_div_bx (
      .clock(clock), .num_mag(bxm), .den_mag(dxm),
      .neg(bx1_ff[NUMW-1] ^ side1_ff.dx[W-1]), .slab_time(tbx));
   rbsi_div #(.FRAC_BITS(F), .COORD_WIDTH(W)) u_div_ay (
      .clock(clock), .num_mag(aym), .den_mag(dym),
      .neg(ay1_ff[NUMW-1] ^ side1_ff.dy[W-1]), .slab_time(tay));
   rbsi_div #(.FRAC_BITS(F), .COORD_WIDTH(W)) u_div_by (
      .clock(clock), .num_mag(bym), .den_mag(dym),
      .neg(by1_ff[NUMW-1] ^ side1_ff.dy[W-1]), .slab_time(tby));

   // side band alongside the dividers
   side_type            sd_ff [DLAT];
   logic [DLAT-1:0]     vd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= '0;
      end else begin
         vd_ff <= {vd_ff[DLAT-2:0], v1_ff};
      end
   end

   always_ff @(posedge clock) begin
      sd_ff[0] <= side1_ff;
      for (int i = 1; i < DLAT; i++) begin
         sd_ff[i] <= sd_ff[i-1];
      end
   end

   // stage 2: near and far per axis
   logic signed [TW-1:0] tax_e, tbx_e, tay_e, tby_e;
   logic signed [TW-1:0] nx_in, fx_in, ny_in, fy_in;
   side_type             sdo;

   always_comb begin
      sdo   = sd_ff[DLAT-1];
      tax_e = TW'(tax);
      tbx_e = TW'(tbx);
      tay_e = TW'(tay);
      tby_e = TW'(tby);
      if (sdo.dzx) begin
         nx_in = T_NEG_INF;
         fx_in = T_POS_INF;
      end else if (tax_e > tbx_e) begin
         nx_in = tbx_e;
         fx_in = tax_e;
      end else begin
         nx_in = tax_e;
         fx_in = tbx_e;
      end
      if (sdo.dzy) begin
         ny_in = T_NEG_INF;
         fy_in = T_POS_INF;
      end else if (tay_e > tby_e) begin
         ny_in = tby_e;
         fy_in = tay_e;
      end else begin
         ny_in = tay_e;
         fy_in = tby_e;
      end
   end

   logic                 v2_ff;
   logic signed [TW-1:0] nx2_ff, fx2_ff, ny2_ff, fy2_ff;
   side_type             side2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= vd_ff[DLAT-1];
      end
   end

   always_ff @(posedge clock) begin
      nx2_ff   <= nx_in;
      fx2_ff   <= fx_in;
      ny2_ff   <= ny_in;
      fy2_ff   <= fy_in;
      side2_ff <= sdo;
   end

   // stage 3: overlap test, entry time and normal
   logic signed [TW-1:0] tnear, tfar;
   logic                 hit_in;
   normal_type           code_in;
   logic signed [W-1:0]  tc_in;

   always_comb begin
      tnear  = (nx2_ff > ny2_ff) ? nx2_ff : ny2_ff;
      tfar   = (fx2_ff < fy2_ff) ? fx2_ff : fy2_ff;
      hit_in = side2_ff.okx && side2_ff.oky && !(nx2_ff > fy2_ff) && !(ny2_ff > fx2_ff)
               && !(tfar < 0);
      if (nx2_ff > ny2_ff) begin
         code_in = side2_ff.dx[W-1] ? NORMAL_POS_X : NORMAL_NEG_X;
      end else if (nx2_ff < ny2_ff) begin
         code_in = side2_ff.dy[W-1] ? NORMAL_POS_Y : NORMAL_NEG_Y;
      end else begin
         code_in = NORMAL_NONE;
      end
      tc_in = (side2_ff.dzx && side2_ff.dzy) ? S_MIN : tnear[W-1:0];
   end

   logic                v3_ff;
   logic                hit3_ff;
   normal_type          code3_ff;
   logic signed [W-1:0] t3_ff;
   side_type            side3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      hit3_ff  <= hit_in;
      code3_ff <= code_in;
      t3_ff    <= tc_in;
      side3_ff <= side2_ff;
   end

   // stage 4: contact products
   logic [W-1:0]   tmag, dxm3, dym3;
   logic [2*W-1:0] prodx_in, prody_in;

   always_comb begin
      tmag     = t3_ff[W-1] ? W'(-t3_ff) : t3_ff;
      dxm3     = side3_ff.dx[W-1] ? W'(-side3_ff.dx) : side3_ff.dx;
      dym3     = side3_ff.dy[W-1] ? W'(-side3_ff.dy) : side3_ff.dy;
      prodx_in = (2*W)'(tmag) * (2*W)'(dxm3);
      prody_in = (2*W)'(tmag) * (2*W)'(dym3);
   end

   logic                v4_ff;
   logic                hit4_ff;
   normal_type          code4_ff;
   logic signed [W-1:0] t4_ff;
   logic [2*W-1:0]      prodx4_ff, prody4_ff;
   logic                negx4_ff, negy4_ff;
   side_type            side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      hit4_ff   <= hit3_ff;
      code4_ff  <= code3_ff;
      t4_ff     <= t3_ff;
      prodx4_ff <= prodx_in;
      prody4_ff <= prody_in;
      negx4_ff  <= t3_ff[W-1] ^ side3_ff.dx[W-1];
      negy4_ff  <= t3_ff[W-1] ^ side3_ff.dy[W-1];
      side4_ff  <= side3_ff;
   end

   // stage 5: contact sums and result beat
   logic [2*W-1:0]       shx, shy;
   logic [W:0]           mx, my;
   logic signed [TW-1:0] sumx, sumy;
   logic signed [W-1:0]  cx_in, cy_in;

   always_comb begin
      shx  = prodx4_ff >> F;
      shy  = prody4_ff >> F;
      mx   = (shx > (2*W)'(M_CAP)) ? M_CAP : shx[W:0];
      my   = (shy > (2*W)'(M_CAP)) ? M_CAP : shy[W:0];
      sumx = TW'(side4_ff.ox) + (negx4_ff ? -$signed(TW'(mx)) : $signed(TW'(mx)));
      sumy = TW'(side4_ff.oy) + (negy4_ff ? -$signed(TW'(my)) : $signed(TW'(my)));
      if (side4_ff.dzx) begin
         cx_in = side4_ff.ox;
      end else if (sumx > S_MAX_T) begin
         cx_in = S_MAX_T[W-1:0];
      end else if (sumx < S_MIN_T) begin
         cx_in = S_MIN;
      end else begin
         cx_in = sumx[W-1:0];
      end
      if (side4_ff.dzy) begin
         cy_in = side4_ff.oy;
      end else if (sumy > S_MAX_T) begin
         cy_in = S_MAX_T[W-1:0];
      end else if (sumy < S_MIN_T) begin
         cy_in = S_MIN;
      end else begin
         cy_in = sumy[W-1:0];
      end
   end

   logic                    strobe_ff;
   logic                    hit_ff;
   logic signed [W-1:0]     entry_ff, cx_ff, cy_ff;
   logic [NORMAL_WIDTH-1:0] code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff   <= hit4_ff;
      entry_ff <= hit4_ff ? t4_ff : '0;
      cx_ff    <= hit4_ff ? cx_in : '0;
      cy_ff    <= hit4_ff ? cy_in : '0;
      code_ff  <= hit4_ff ? code4_ff : NORMAL_NONE;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_entry_time  = entry_ff;
   assign rsp_contact_x   = cx_ff;
   assign rsp_contact_y   = cy_ff;
   assign rsp_normal_code = code_ff;

   `include "ray_box_slab_intersect_assert.svh"

   `RBSI_ASSERT(a_latency, clock, reset, start && !busy |-> ##LAT rsp_strobe,
      "result beat missing after fixed latency")
   `RBSI_ASSERT(a_miss_zero, clock, reset,
      rsp_strobe && !rsp_hit |-> rsp_entry_time == 0 && rsp_contact_x == 0
      && rsp_contact_y == 0 && rsp_normal_code == NORMAL_NONE,
      "miss beat carries nonzero payload")
   `RBSI_ASSERT(a_no_spurious, clock, reset,
      rsp_strobe |-> $past(v4_ff), "result beat without a matching item")
   `RBSI_ASSERT_NRST(a_reset_clears, clock, reset |=> !v0_ff && !rsp_strobe,
      "valid bits not cleared by reset")

endmodule
`default_nettype wire
